/* rtl/pcb_pkg.sv */
// shared types and constants for the polyline corner bevel block
// no dependencies; imported by pcb_vec, pcb_core and polyline_corner_bevel
package pcb_pkg;

    localparam int MaxLevels = 5;
    localparam int FracBits  = 16;
    localparam int CoordW    = 32;
    localparam int DistW     = 31;
    localparam int IterW     = 3;
    localparam int CfgIdxW   = 1;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CfgDistance   = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgIterations = 1'b1;

    // three coordinates, x in the lowest slot
    typedef logic [2:0][CoordW-1:0] t_point;

    // request to the vector unit
    typedef struct packed {
        logic start;
        logic edge_mode;   // 1: edge length, 0: set-back point
    } t_vec_cmd;

    // point request from the corner sequencer to the output stage
    typedef struct packed {
        logic   valid;
        logic   last;
        t_point point;
    } t_emit;

endpackage

/* rtl/pcb_vec.sv */
// vector unit: one shared multiplier, bitwise square root and restoring divider
// computes a set-back point or the next level's distance; uses pcb_pkg
module pcb_vec
    import pcb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_vec_cmd         i_cmd,
    input  t_point           i_from,
    input  t_point           i_to,
    input  logic [DistW-1:0] i_dist,
    output logic             o_done,
    output t_point           o_point,
    output logic [DistW-1:0] o_next_dist
);

    localparam logic [3:0] V_IDLE = 4'd0;
    localparam logic [3:0] V_NORM = 4'd1;
    localparam logic [3:0] V_SQ   = 4'd2;
    localparam logic [3:0] V_ROOT = 4'd3;
    localparam logic [3:0] V_MUL  = 4'd4;
    localparam logic [3:0] V_DIVI = 4'd5;
    localparam logic [3:0] V_DIVS = 4'd6;
    localparam logic [3:0] V_ADD  = 4'd7;
    localparam logic [3:0] V_DONE = 4'd8;

    logic [3:0]        r_state;
    logic              r_edge;
    logic              r_half;
    t_point            r_from;
    logic [DistW-1:0]  r_dist;
    logic [2:0][31:0]  r_mag;
    logic [2:0]        r_neg;
    logic [31:0]       r_max;
    logic [1:0]        r_idx;
    logic [63:0]       r_sum;
    logic [63:0]       r_bit;
    logic [63:0]       r_res;
    logic [61:0]       r_prod;
    logic [31:0]       r_rem;
    logic [32:0]       r_num;
    logic [32:0]       r_q;
    logic [5:0]        r_cnt;
    t_point            r_point;
    logic [DistW-1:0]  r_nd;

    logic [2:0][32:0]  diff;
    logic [2:0][31:0]  mag_in;
    logic [31:0]       max_in;
    logic [30:0]       mul_a;
    logic [30:0]       mul_b;
    logic [61:0]       prod;
    logic [63:0]       root_try;
    logic [31:0]       len;
    logic [32:0]       len_x2;
    logic [63:0]       num;
    logic [32:0]       div_try;
    logic              div_ge;
    logic [34:0]       add_sum;
    logic [31:0]       add_sat;

    // differences and magnitudes of the incoming pair
    always_comb begin
        max_in = '0;
        for (int i = 0; i < 3; i++) begin
            diff[i]   = {i_to[i][31], i_to[i]} - {i_from[i][31], i_from[i]};
            mag_in[i] = diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
            if (mag_in[i] > max_in) max_in = mag_in[i];
        end
    end

    // the one multiplier: squares, then magnitude times distance
    assign mul_a = r_mag[r_idx][30:0];
    assign mul_b = (r_state == V_SQ) ? r_mag[r_idx][30:0] : r_dist;
    assign prod  = {31'd0, mul_a} * {31'd0, mul_b};

    // square root step, divider step, final add with saturation
    assign root_try = r_res + r_bit;
    assign len      = r_res[31:0];
    assign len_x2   = r_half ? {len, 1'b0} : {1'b0, len};
    assign num      = {2'd0, r_prod} + {33'd0, len[31:1]};
    assign div_try  = {r_rem, r_num[32]};
    assign div_ge   = div_try >= {1'b0, len};

    always_comb begin
        if (r_neg[r_idx]) begin
            add_sum = {{3{r_from[r_idx][31]}}, r_from[r_idx]} - {2'd0, r_q};
        end else begin
            add_sum = {{3{r_from[r_idx][31]}}, r_from[r_idx]} + {2'd0, r_q};
        end
        if (add_sum[34] && !(&add_sum[33:31])) begin
            add_sat = 32'h8000_0000;
        end else if (!add_sum[34] && (|add_sum[33:31])) begin
            add_sat = 32'h7FFF_FFFF;
        end else begin
            add_sat = add_sum[31:0];
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
        end else begin
            case (r_state)
                V_IDLE: begin
                    if (i_cmd.start) begin
                        if (i_cmd.edge_mode)   r_state <= V_SQ;
                        else if (max_in == '0) r_state <= V_DONE;
                        else                   r_state <= V_NORM;
                    end
                end
                V_NORM: begin
                    if (!r_max[31] && r_max[30]) r_state <= V_SQ;
                end
                V_SQ: begin
                    if (r_idx == 2'd2) r_state <= V_ROOT;
                end
                V_ROOT: begin
                    if (r_bit == 64'd1) r_state <= r_edge ? V_DONE : V_MUL;
                end
                V_MUL:  r_state <= V_DIVI;
                V_DIVI: r_state <= V_DIVS;
                V_DIVS: begin
                    if (r_cnt == 6'd1) r_state <= V_ADD;
                end
                V_ADD:  r_state <= (r_idx == 2'd2) ? V_DONE : V_MUL;
                V_DONE: r_state <= V_IDLE;
                default: r_state <= V_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            V_IDLE: begin
                if (i_cmd.start) begin
                    r_edge  <= i_cmd.edge_mode;
                    r_from  <= i_from;
                    r_point <= i_from;
                    r_dist  <= i_dist;
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_res   <= '0;
                    r_max   <= max_in;
                    r_half  <= i_cmd.edge_mode && max_in[31];
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= diff[i][32];
                        r_mag[i] <= (i_cmd.edge_mode && max_in[31]) ? (mag_in[i] >> 1)
                                                                   : mag_in[i];
                    end
                end
            end
            V_NORM: begin
                if (r_max[31]) begin
                    r_max <= r_max >> 1;
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (!r_max[30]) begin
                    r_max <= r_max << 1;
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end
            end
            V_SQ: begin
                r_sum <= r_sum + {2'd0, prod};
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            V_ROOT: begin
                if (r_sum >= root_try) begin
                    r_sum <= r_sum - root_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            V_MUL: r_prod <= prod;
            V_DIVI: begin
                r_rem <= {1'b0, num[63:33]};
                r_num <= num[32:0];
                r_q   <= '0;
                r_cnt <= 6'd33;
            end
            V_DIVS: begin
                r_rem <= div_ge ? 32'(div_try - {1'b0, len}) : div_try[31:0];
                r_q   <= {r_q[31:0], div_ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 6'd1;
            end
            V_ADD: begin
                r_point[r_idx] <= add_sat;
                r_idx          <= r_idx + 2'd1;
            end
            V_DONE: r_nd <= len_x2[32:2];
            default: ;
        endcase
    end

    assign o_done      = (r_state == V_DONE);
    assign o_point     = r_point;
    assign o_next_dist = r_edge ? len_x2[32:2] : r_nd;

endmodule

/* rtl/pcb_core.sv */
// corner sequencer: walks the recursive cut depth first with an explicit frame stack
// drives the shared vector unit pcb_vec; uses pcb_pkg
module pcb_core
    import pcb_pkg::*;
#(
    parameter int MAX_LEVELS = MaxLevels
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_tail,
    input  t_point           i_p1,
    input  t_point           i_p2,
    input  t_point           i_p3,
    input  logic [DistW-1:0] i_dist,
    input  logic [IterW-1:0] i_levels,
    output logic             o_done,
    output t_emit            o_emit,
    input  logic             i_emit_ready,
    output t_vec_cmd         o_vec_cmd,
    output t_point           o_vec_from,
    output t_point           o_vec_to,
    output logic [DistW-1:0] o_vec_dist,
    input  logic             i_vec_done,
    input  t_point           i_vec_point,
    input  logic [DistW-1:0] i_vec_nd
);

    localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_A    = 3'd1;
    localparam logic [2:0] C_B    = 3'd2;
    localparam logic [2:0] C_E    = 3'd3;
    localparam logic [2:0] C_EMA  = 3'd4;
    localparam logic [2:0] C_EMB  = 3'd5;
    localparam logic [2:0] C_POP  = 3'd6;
    localparam logic [2:0] C_DONE = 3'd7;

    logic [2:0]        r_state;
    logic              r_wait;
    logic              r_tail;
    logic [IterW-1:0]  r_levels;
    logic [IW-1:0]     r_sp;
    logic [MAX_LEVELS-1:0] r_ph;
    t_point            r_p1;
    t_point            r_p2;
    t_point            r_p3;
    t_point            r_a;
    t_point            r_b;
    logic [DistW-1:0]  r_dist;

    // frame stack: two cut points, far neighbour and distance of each open frame
    t_point            r_st_a  [MAX_LEVELS];
    t_point            r_st_b  [MAX_LEVELS];
    t_point            r_st_p3 [MAX_LEVELS];
    logic [DistW-1:0]  r_st_nd [MAX_LEVELS];

    logic [IW-1:0]     top;
    logic              leaf;
    logic              all_second;

    assign top  = r_sp - 1'b1;
    assign leaf = (int'(r_sp) + 1 == int'(r_levels));

    // the second point of a leaf is the last one when every open frame is in its second half
    always_comb begin
        all_second = 1'b1;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (IW'(k) < r_sp && !r_ph[k]) all_second = 1'b0;
        end
    end

    // vector unit request
    always_comb begin
        o_vec_cmd.start     = !r_wait && (r_state == C_A || r_state == C_B || r_state == C_E);
        o_vec_cmd.edge_mode = (r_state == C_E);
        o_vec_from          = (r_state == C_E) ? r_a : r_p2;
        o_vec_to            = (r_state == C_A) ? r_p1 : ((r_state == C_B) ? r_p3 : r_b);
        o_vec_dist          = r_dist;
    end

    // point requests
    assign o_emit.valid = (r_state == C_EMA) || (r_state == C_EMB);
    assign o_emit.last  = (r_state == C_EMB) && all_second && !r_tail;
    assign o_emit.point = (r_state == C_EMA) ? r_a : r_b;
    assign o_done       = (r_state == C_DONE);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_wait  <= 1'b0;
            r_sp    <= '0;
            r_ph    <= '0;
        end else begin
            if (o_vec_cmd.start) r_wait <= 1'b1;
            else if (i_vec_done) r_wait <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_A;
                        r_sp    <= '0;
                    end
                end
                C_A: begin
                    if (i_vec_done) r_state <= C_B;
                end
                C_B: begin
                    if (i_vec_done) r_state <= leaf ? C_EMA : C_E;
                end
                C_E: begin
                    if (i_vec_done) begin
                        r_ph[r_sp] <= 1'b0;
                        r_sp       <= r_sp + 1'b1;
                        r_state    <= C_A;
                    end
                end
                C_EMA: begin
                    if (i_emit_ready) r_state <= C_EMB;
                end
                C_EMB: begin
                    if (i_emit_ready) r_state <= C_POP;
                end
                C_POP: begin
                    if (r_sp == '0) begin
                        r_state <= C_DONE;
                    end else if (!r_ph[top]) begin
                        r_ph[top] <= 1'b1;
                        r_state   <= C_A;
                    end else begin
                        r_sp <= top;
                    end
                end
                C_DONE: r_state <= C_IDLE;
                default: r_state <= C_IDLE;
            endcase
        end
    end

    // working points and frame payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_p1     <= i_p1;
                    r_p2     <= i_p2;
                    r_p3     <= i_p3;
                    r_dist   <= i_dist;
                    r_levels <= i_levels;
                    r_tail   <= i_tail;
                end
            end
            C_A: begin
                if (i_vec_done) r_a <= i_vec_point;
            end
            C_B: begin
                if (i_vec_done) r_b <= i_vec_point;
            end
            C_E: begin
                if (i_vec_done) begin
                    r_st_a[r_sp]  <= r_a;
                    r_st_b[r_sp]  <= r_b;
                    r_st_p3[r_sp] <= r_p3;
                    r_st_nd[r_sp] <= i_vec_nd;
                    r_p2          <= r_a;
                    r_p3          <= r_b;
                    r_dist        <= i_vec_nd;
                end
            end
            C_POP: begin
                if (r_sp != '0 && !r_ph[top]) begin
                    r_p1   <= r_st_a[top];
                    r_p2   <= r_st_b[top];
                    r_p3   <= r_st_p3[top];
                    r_dist <= r_st_nd[top];
                end
            end
            default: ;
        endcase
    end

    // open frames never reach the leaf level
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != C_IDLE && r_state != C_DONE) |-> (int'(r_sp) < int'(r_levels)))
        else $error("frame stack deeper than the level count");

    // the vector unit answers only while a request is outstanding
    a_vec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vec_done |-> r_wait)
        else $error("vector unit done without a request");

    // no point leaves while the vector unit is busy
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> !r_wait)
        else $error("point request during vector work");

    // a marked last point ends the corner
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last && i_emit_ready) |=> (r_state == C_POP) ##1
        (r_state == C_POP || r_state == C_DONE))
        else $error("last point before the end of the corner");

endmodule

/* rtl/polyline_corner_bevel.sv */
// top level of the polyline corner bevel block: streams, registers, point history
// instantiates pcb_core and pcb_vec; uses pcb_pkg
//
// Input stream carries one 3D point per request (x, y, z signed Q16.16 in tdata,
// tlast marks the final point of a line). Output stream carries emitted points
// in the same format; tlast marks the last point caused by one input request.
// The first point of a line goes from the tail state into the output register. The
// second point gives nothing unless it ends the line. Each later point starts a corner
// cut that yields 2^n points at level count n. The one vector unit computes
// 2^(n+1) - 2 set-back points, each by normalize, squares, square root and three
// divisions, and 2^(n-1) - 1 edge lengths, each by squares and square root. Its
// divider and square root loop take most of the time of a corner.
// o_s_tready is high only while the block is idle. A stalled receiver holds the
// output register and the sequencer waits; nothing is lost. After reset the
// distance is 0.1 in the point format, the level count is 1 and the line is
// empty. Configuration writes are taken any cycle and meant for idle periods.
module polyline_corner_bevel
    import pcb_pkg::*;
#(
    parameter int MAX_LEVELS = MaxLevels,
    parameter int FRAC_BITS  = FracBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [95:0]        i_s_tdata,   // point_x, point_y, point_z
    input  logic               i_s_tlast,   // line_end
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [95:0]        o_m_tdata,   // out_x, out_y, out_z
    output logic               o_m_tlast,   // run_last
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DistW-1:0]   i_cfg_data
);

    localparam logic [DistW-1:0] DistResetVal = DistW'(((1 << FRAC_BITS) + 5) / 10);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_CUT  = 2'd1;
    localparam logic [1:0] T_TAIL = 2'd2;

    logic [1:0]        r_state;
    logic [DistW-1:0]  r_dist;
    logic [IterW-1:0]  r_iter;
    t_point            r_earlier;
    t_point            r_middle;
    logic [1:0]        r_seen;
    t_point            r_cur;
    logic              r_tail;
    logic              r_ov;
    t_point            r_out;
    logic              r_olast;

    t_point            in_pt;
    logic              accept;
    logic              out_free;

    t_emit             emit;
    logic              core_done;
    t_vec_cmd          vec_cmd;
    t_point            vec_from;
    t_point            vec_to;
    logic [DistW-1:0]  vec_dist;
    logic              vec_done;
    t_point            vec_point;
    logic [DistW-1:0]  vec_nd;

    assign in_pt      = i_s_tdata;
    assign o_s_tready = (r_state == T_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ov || i_m_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DistResetVal;
            r_iter <= IterW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgDistance: r_dist <= i_cfg_data;
                CfgIterations: begin
                    if (i_cfg_data >= DistW'(1) && i_cfg_data <= DistW'(MAX_LEVELS))
                        r_iter <= i_cfg_data[IterW-1:0];
                end
                default: ;
            endcase
        end
    end

    // line history and request flow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_seen    <= '0;
            r_earlier <= '0;
            r_middle  <= '0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        if (r_seen == 2'd2)                  r_state <= T_CUT;
                        else if (r_seen == 2'd0 || i_s_tlast) r_state <= T_TAIL;
                        if (i_s_tlast) begin
                            r_earlier <= '0;
                            r_middle  <= '0;
                            r_seen    <= '0;
                        end else begin
                            r_earlier <= r_middle;
                            r_middle  <= in_pt;
                            if (r_seen != 2'd2) r_seen <= r_seen + 2'd1;
                        end
                    end
                end
                T_CUT: begin
                    if (core_done) r_state <= r_tail ? T_TAIL : T_IDLE;
                end
                T_TAIL: begin
                    if (out_free) r_state <= T_IDLE;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur  <= in_pt;
            r_tail <= i_s_tlast;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= (r_state == T_TAIL) || emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_state == T_TAIL) begin
                r_out   <= r_cur;
                r_olast <= 1'b1;
            end else if (emit.valid) begin
                r_out   <= emit.point;
                r_olast <= emit.last;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_olast;

    pcb_core #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept && r_seen == 2'd2),
        .i_tail       (i_s_tlast),
        .i_p1         (r_earlier),
        .i_p2         (r_middle),
        .i_p3         (in_pt),
        .i_dist       (r_dist),
        .i_levels     (r_iter),
        .o_done       (core_done),
        .o_emit       (emit),
        .i_emit_ready (out_free && r_state == T_CUT),
        .o_vec_cmd    (vec_cmd),
        .o_vec_from   (vec_from),
        .o_vec_to     (vec_to),
        .o_vec_dist   (vec_dist),
        .i_vec_done   (vec_done),
        .i_vec_point  (vec_point),
        .i_vec_nd     (vec_nd)
    );

    pcb_vec u_vec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (vec_cmd),
        .i_from      (vec_from),
        .i_to        (vec_to),
        .i_dist      (vec_dist),
        .o_done      (vec_done),
        .o_point     (vec_point),
        .o_next_dist (vec_nd)
    );

endmodule

/* tb/tb_polyline_corner_bevel.sv */
// testbench for polyline_corner_bevel: streams polylines, predicts bevelled points
// in a behavioral model and checks every output request; depends on rtl pcb_pkg

module tb_polyline_corner_bevel
    import pcb_pkg::*;
;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_bevel_pt;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [95:0]        i_s_tdata;
    logic               i_s_tlast;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [95:0]        o_m_tdata;
    logic               o_m_tlast;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [DistW-1:0]   i_cfg_data;

    // model state
    logic [30:0]        mdl_dist;
    logic [2:0]         mdl_levels;
    logic signed [31:0] hist_old [3];
    logic signed [31:0] hist_mid [3];
    int                 pts_seen;

    t_bevel_pt expected_pts[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    polyline_corner_bevel uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // point_x, point_y, point_z
        .i_s_tlast   (i_s_tlast),    // line_end
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // out_x, out_y, out_z
        .o_m_tlast   (o_m_tlast),    // run_last
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // set-back offset from corner toward target, length seg_dist
    task automatic setback_toward(input logic signed [31:0] corner[3],
                                  input logic signed [31:0] target[3],
                                  input logic [31:0] seg_dist,
                                  output logic signed [31:0] pt[3]);
        logic [63:0]        mag[3];
        logic               neg[3];
        logic [63:0]        mx;
        logic [63:0]        sum;
        logic [63:0]        len;
        logic [63:0]        q;
        logic signed [63:0] d;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            d      = 64'(target[i]) - 64'(corner[i]);
            neg[i] = d < 0;
            mag[i] = neg[i] ? 64'(-d) : 64'(d);
            if (mag[i] > mx) mx = mag[i];
            pt[i] = corner[i];
        end
        if (mx == 0) return;
        while (mx >= 64'd1 << 31) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < 64'd1 << 30) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            mx = mx << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q     = (mag[i] * 64'(seg_dist) + (len >> 1)) / len;
            pt[i] = clip32(neg[i] ? 64'(corner[i]) - $signed(q) : 64'(corner[i]) + $signed(q));
        end
    endtask

    function automatic logic [63:0] span_length(input logic signed [31:0] a[3],
                                                input logic signed [31:0] b[3]);
        logic [63:0]        mag[3];
        logic [63:0]        mx;
        logic [63:0]        sum;
        logic signed [63:0] d;
        int                 sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            d      = 64'(b[i]) - 64'(a[i]);
            mag[i] = d < 0 ? 64'(-d) : 64'(d);
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx >= 64'd1 << 31) begin
            sh = 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        return root_floor(sum) << sh;
    endfunction

    function automatic void queue_point(input logic signed [31:0] p[3]);
        t_bevel_pt e;
        e.x = p[0];
        e.y = p[1];
        e.z = p[2];
        e.last = 1'b0;
        expected_pts.push_back(e);
    endfunction

    // recursive corner cut, depth first
    task automatic cut_corner(input logic signed [31:0] p1[3], input logic signed [31:0] p2[3],
                              input logic signed [31:0] p3[3], input logic [31:0] seg_dist,
                              input int levels);
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        logic [63:0]        nd;
        setback_toward(p2, p1, seg_dist, a);
        setback_toward(p2, p3, seg_dist, b);
        if (levels > 1) begin
            nd = span_length(a, b) >> 2;
            if (nd > 64'h7fffffff) nd = 64'h7fffffff;
            cut_corner(p1, a, b, nd[31:0], levels - 1);
            cut_corner(a, b, p3, nd[31:0], levels - 1);
        end else begin
            queue_point(a);
            queue_point(b);
        end
    endtask

    task automatic predict_point(input logic [95:0] data, input logic line_end);
        logic signed [31:0] p[3];
        int                 n0;
        n0 = expected_pts.size();
        p[0] = data[31:0];
        p[1] = data[63:32];
        p[2] = data[95:64];
        if (pts_seen == 0) begin
            queue_point(p);
        end else begin
            if (pts_seen >= 2) cut_corner(hist_old, hist_mid, p, {1'b0, mdl_dist}, mdl_levels);
            if (line_end) queue_point(p);
        end
        if (line_end) begin
            for (int i = 0; i < 3; i++) begin
                hist_old[i] = 0;
                hist_mid[i] = 0;
            end
            pts_seen = 0;
        end else begin
            hist_old = hist_mid;
            hist_mid = p;
            if (pts_seen < 2) pts_seen++;
        end
        if (expected_pts.size() > n0) expected_pts[expected_pts.size() - 1].last = 1'b1;
    endtask

    // register write, taken while idle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CfgDistance) mdl_dist = val;
        else if (val >= 1 && val <= MaxLevels) mdl_levels = val[2:0];
        @(posedge i_clk);
    endtask

    // one input request; valid stays high when the next request follows at once
    task automatic send_point(input logic [95:0] data, input logic line_end);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= line_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_point(data, line_end);
    endtask

    // wait until every expected point arrived, then let the block settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(2000) - 1000;
            3: return $urandom;
            default: return ($urandom_range(200) - 100) << 16;
        endcase
    endfunction

    // output checker and receiver stalls
    always @(posedge i_clk) begin
        t_bevel_pt e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_pts.size() == 0) begin
                $error("unexpected point %h", o_m_tdata);
                fail_count++;
            end else begin
                e = expected_pts.pop_front();
                if (o_m_tdata[31:0] !== e.x) begin
                    $error("out_x expected %h actual %h", e.x, o_m_tdata[31:0]);
                    fail_count++;
                end
                if (o_m_tdata[63:32] !== e.y) begin
                    $error("out_y expected %h actual %h", e.y, o_m_tdata[63:32]);
                    fail_count++;
                end
                if (o_m_tdata[95:64] !== e.z) begin
                    $error("out_z expected %h actual %h", e.z, o_m_tdata[95:64]);
                    fail_count++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("run_last expected %b actual %b", e.last, o_m_tlast);
                    fail_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // directed: extremes, special cases, config edges
    task automatic test_directed();
        send_point({32'sd5, 32'sd6, 32'sd7}, 1'b1);                      // single point
        send_point({32'd0, 32'd0, 32'd0}, 1'b0);
        send_point({32'd0, 32'd0, 32'h00010000}, 1'b1);                  // two points
        send_point({32'd0, 32'd0, 32'd0}, 1'b0);
        send_point({32'd0, 32'd0, 32'h000a0000}, 1'b0);
        send_point({32'd0, 32'h000a0000, 32'h000a0000}, 1'b0);
        send_point({32'd0, 32'h000a0000, 32'h000a0000}, 1'b0);           // zero-length direction
        send_point({32'h7fffffff, 32'h80000000, 32'h7fffffff}, 1'b0);
        send_point({32'h80000000, 32'h7fffffff, 32'h80000000}, 1'b0);
        send_point({32'hffffffff, 32'h00000000, 32'h7fffffff}, 1'b1);
        drain();
        write_reg(CfgIterations, 31'd0);                                 // ignored
        write_reg(CfgIterations, 31'd6);                                 // ignored
        write_reg(CfgDistance, 31'h7fffffff);
        send_point({32'd0, 32'd0, 32'd0}, 1'b0);
        send_point({32'd0, 32'h00100000, 32'd0}, 1'b0);
        send_point({32'h80000000, 32'h7fffffff, 32'h7fffffff}, 1'b1);
        drain();
        write_reg(CfgDistance, 31'd0);
        write_reg(CfgIterations, 31'd5);
        send_point({32'd0, 32'd0, 32'd0}, 1'b0);
        send_point({32'd0, 32'h00100000, 32'd0}, 1'b0);
        send_point({32'd0, 32'h00100000, 32'h00100000}, 1'b1);
        drain();
    endtask

    // random well-formed lines with random content, some short ones
    task automatic test_random_lines(input int n_items, input int send_pct, input int recv_pct);
        int len;
        int sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 8);
            for (int k = 0; k < len; k++) begin
                send_point({rand_coord(), rand_coord(), rand_coord()}, k == len - 1);
                sent++;
            end
        end
        drain();
    endtask

    task automatic set_random_config(input int levels_max);
        write_reg(CfgIterations, DistW'($urandom_range(1, levels_max)));
        write_reg(CfgDistance,
                  DistW'(($urandom_range(1) != 0) ? $urandom_range(1 << 20) : $urandom));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tlast      = 1'b0;
        i_m_tready     = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mdl_dist       = 31'd6554;
        mdl_levels     = 3'd1;
        pts_seen       = 0;
        for (int i = 0; i < 3; i++) begin
            hist_old[i] = 0;
            hist_mid[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_random_config(2);
        test_random_lines(100, 0, 0);
        set_random_config(3);
        test_random_lines(90, 73, 0);
        set_random_config(2);
        test_random_lines(90, 0, 73);
        set_random_config(5);
        test_random_lines(20, 17, 17);
        set_random_config(3);
        test_random_lines(60, 17, 17);

        if (fail_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    // run limit
    initial begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
rtl/pcb_pkg.sv
rtl/pcb_vec.sv
rtl/pcb_core.sv
rtl/polyline_corner_bevel.sv
tb/tb_polyline_corner_bevel.sv
